// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the encoder RTL.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ALEBE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ALEBE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ALEBE_ASSERT(label, prop, msg)
`define ALEBE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/alebe_pkg.sv -----
// Shared types and constants of the addressable LED bit encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package alebe_pkg;

	localparam int unsigned PIXEL_W = 24;
	localparam int unsigned COUNT_W = 11;

	// frame lengths above this saturate
	localparam logic [COUNT_W-1:0] MAX_PIXELS = 11'd1024;

	// configuration register indexes
	localparam logic [2:0] CFG_COLOR_ORDER = 3'd0;
	localparam logic [2:0] CFG_FRAME_LENGTH = 3'd1;
	localparam logic [2:0] CFG_ZERO_HIGH = 3'd2;
	localparam logic [2:0] CFG_ZERO_LOW = 3'd3;
	localparam logic [2:0] CFG_ONE_HIGH = 3'd4;
	localparam logic [2:0] CFG_ONE_LOW = 3'd5;
	localparam logic [2:0] CFG_RESET_GAP = 3'd6;

	// colour orders on the wire
	localparam logic [2:0] ORDER_RGB = 3'd0;
	localparam logic [2:0] ORDER_RBG = 3'd1;
	localparam logic [2:0] ORDER_GRB = 3'd2;
	localparam logic [2:0] ORDER_GBR = 3'd3;
	localparam logic [2:0] ORDER_BRG = 3'd4;
	localparam logic [2:0] ORDER_BGR = 3'd5;

	// reset values of the registers
	localparam logic [2:0] RST_COLOR_ORDER = ORDER_GRB;
	localparam logic [10:0] RST_FRAME_LENGTH = 11'd1;
	localparam logic [4:0] RST_ZERO_HIGH = 5'd14;
	localparam logic [5:0] RST_ZERO_LOW = 6'd36;
	localparam logic [5:0] RST_ONE_HIGH = 6'd38;
	localparam logic [4:0] RST_ONE_LOW = 5'd12;
	localparam logic [15:0] RST_RESET_GAP = 16'd13043;

	// one classified pixel waiting for the serializer
	typedef struct packed {
		logic frame_end;
		logic [PIXEL_W-1:0] wire_word;
	} entry_t;

	// line timing handed to the serializer
	typedef struct packed {
		logic [4:0] zero_high;
		logic [5:0] zero_low;
		logic [5:0] one_high;
		logic [4:0] one_low;
		logic [15:0] reset_gap;
	} timing_t;

endpackage

`default_nettype wire

// ----- rtl/alebe_front.sv -----
// Front end: reorders colour bytes and marks the pixel that ends a frame.
// Depends on alebe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alebe_front import alebe_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [PIXEL_W-1:0] pixel_word,
	input wire logic [2:0] color_order,
	input wire logic [COUNT_W-1:0] frame_length,
	output entry_t entry
);

	logic [COUNT_W-1:0] pixel_count_q;
	logic [COUNT_W-1:0] next_count;
	logic [COUNT_W-1:0] eff_len;
	logic [7:0] red, green, blue;
	logic [PIXEL_W-1:0] wire_word;
	logic frame_end;

	assign red = pixel_word[23:16];
	assign green = pixel_word[15:8];
	assign blue = pixel_word[7:0];

	always_comb begin
		case (color_order)
			ORDER_RBG: wire_word = {red, blue, green};
			ORDER_GRB: wire_word = {green, red, blue};
			ORDER_GBR: wire_word = {green, blue, red};
			ORDER_BRG: wire_word = {blue, red, green};
			ORDER_BGR: wire_word = {blue, green, red};
			default: wire_word = {red, green, blue};
		endcase
	end

	always_comb begin
		if (frame_length == '0) begin
			eff_len = COUNT_W'(1);
		end else if (frame_length > MAX_PIXELS) begin
			eff_len = MAX_PIXELS;
		end else begin
			eff_len = frame_length;
		end
	end

	assign next_count = pixel_count_q + COUNT_W'(1);
	assign frame_end = next_count >= eff_len;
	assign entry = {frame_end, wire_word};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= '0;
		end else if (push) begin
			pixel_count_q <= frame_end ? '0 : next_count;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/alebe_queue.sv -----
// Pixel queue between front end and serializer, with a registered head.
// Depends on alebe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alebe_queue import alebe_pkg::*; #(
	parameter int unsigned DEPTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire entry_t push_entry,
	output logic full,
	output logic head_valid,
	output entry_t head_entry,
	input wire logic head_pop
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic head_valid_q;
	entry_t head_data_q;
	logic mem_pop;

	assign full = cnt_q == CW'(DEPTH);
	// refill the head whenever it is empty or being taken
	assign mem_pop = (cnt_q != '0) && (!head_valid_q || head_pop);
	assign head_valid = head_valid_q;
	assign head_entry = head_data_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
		if (mem_pop) begin
			head_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (mem_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(mem_pop);
			if (mem_pop) begin
				head_valid_q <= 1'b1;
			end else if (head_pop) begin
				head_valid_q <= 1'b0;
			end
		end
	end

	`ALEBE_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue count above depth")
	`ALEBE_ASSERT(a_no_overflow, !(push && full), "push into full queue")
	`ALEBE_ASSERT_NEXT(a_head_hold, head_valid_q && !head_pop, head_valid_q && $stable(head_data_q), "head lost")

endmodule

`default_nettype wire

// ----- rtl/alebe_back.sv -----
// Serializer: turns each queued pixel into 24 bit symbols and an optional
// reset symbol, one beat per cycle while m_tready allows, through an output register. Depends on alebe_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alebe_back import alebe_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic head_valid,
	input wire entry_t head_entry,
	output logic head_pop,
	input wire timing_t timing,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [23:0] m_tdata, // bit_value, high_cycles[5:0], low_cycles[15:0], pad
	output logic m_tuser, // is_reset
	output logic m_tlast
);

	localparam logic [4:0] STEP_LAST_BIT = 5'd23;
	localparam logic [4:0] STEP_RESET = 5'd24;

	logic busy_q;
	logic [PIXEL_W-1:0] word_q;
	logic fe_q;
	logic [4:0] step_q;
	logic adv;
	logic sym_last;
	logic sym_bit;
	logic sym_reset;
	logic [5:0] sym_high;
	logic [15:0] sym_low;

	logic valid_q;
	logic bit_q;
	logic [5:0] high_q;
	logic [15:0] low_q;
	logic reset_q;
	logic last_q;

	assign adv = busy_q && (!valid_q || m_tready);
	assign sym_reset = step_q == STEP_RESET;
	assign sym_bit = !sym_reset && word_q[PIXEL_W-1];
	assign sym_last = sym_reset || ((step_q == STEP_LAST_BIT) && !fe_q);
	assign head_pop = head_valid && (!busy_q || (adv && sym_last));

	always_comb begin
		if (sym_reset) begin
			sym_high = '0;
			sym_low = timing.reset_gap;
		end else if (sym_bit) begin
			sym_high = timing.one_high;
			sym_low = {11'd0, timing.one_low};
		end else begin
			sym_high = {1'b0, timing.zero_high};
			sym_low = {10'd0, timing.zero_low};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (head_pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (adv) begin
				if (sym_last) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 5'd1;
			end
			if (adv) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			word_q <= head_entry.wire_word;
			fe_q <= head_entry.frame_end;
		end else if (adv) begin
			// advance to the next bit, most significant first
			word_q <= {word_q[PIXEL_W-2:0], 1'b0};
		end
		if (adv) begin
			bit_q <= sym_bit;
			high_q <= sym_high;
			low_q <= sym_low;
			reset_q <= sym_reset;
			last_q <= sym_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {1'b0, low_q, high_q, bit_q};
	assign m_tuser = reset_q;
	assign m_tlast = last_q;

	`ALEBE_ASSERT(a_step_bound, !busy_q || step_q <= STEP_RESET, "step out of range")
	`ALEBE_ASSERT(a_reset_needs_fe, !(busy_q && sym_reset) || fe_q, "reset without frame end")
	`ALEBE_ASSERT(a_reset_beat_last, !(valid_q && reset_q) || (last_q && !bit_q && high_q == '0), "bad reset beat")

endmodule

`default_nettype wire

// ----- rtl/addressable_led_bit_encoder_unit.sv -----
// Top level of the addressable LED bit encoder: configuration registers,
// front end, pixel queue and serializer. Depends on alebe_pkg and the alebe_* modules.
//
// Each accepted pixel word (red 23..16, green 15..8, blue 7..0) yields 24 bit
// symbols, most significant wire bit first, plus a reset symbol (tuser high)
// when the pixel completes the frame; tlast marks the final beat of each pixel.
// The serializer sends one beat per clock while m_tready allows, so a pixel occupies
// the output for its bit beats, plus the reset beat when it ends a frame; that single
// output register sets the sustained rate. Pixels are accepted every cycle while the
// QUEUE_DEPTH-entry queue has room; a pixel accepted into an idle block passes through the
// queue memory, head, serializer word and output registers. Write the registers only while idle.
`timescale 1ns / 1ps
`default_nettype none

module addressable_led_bit_encoder_unit import alebe_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_wdata,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [23:0] s_tdata, // pixel_word
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [23:0] m_tdata, // bit_value, high_cycles[5:0], low_cycles[15:0], pad
	output logic m_tuser, // is_reset
	output logic m_tlast
);

	logic [2:0] color_order_q;
	logic [10:0] frame_length_q;
	timing_t timing_q;
	logic push;
	logic full;
	entry_t push_entry;
	logic head_valid;
	entry_t head_entry;
	logic head_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_order_q <= RST_COLOR_ORDER;
			frame_length_q <= RST_FRAME_LENGTH;
			timing_q.zero_high <= RST_ZERO_HIGH;
			timing_q.zero_low <= RST_ZERO_LOW;
			timing_q.one_high <= RST_ONE_HIGH;
			timing_q.one_low <= RST_ONE_LOW;
			timing_q.reset_gap <= RST_RESET_GAP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLOR_ORDER: color_order_q <= cfg_wdata[2:0];
				CFG_FRAME_LENGTH: frame_length_q <= cfg_wdata[10:0];
				CFG_ZERO_HIGH: timing_q.zero_high <= cfg_wdata[4:0];
				CFG_ZERO_LOW: timing_q.zero_low <= cfg_wdata[5:0];
				CFG_ONE_HIGH: timing_q.one_high <= cfg_wdata[5:0];
				CFG_ONE_LOW: timing_q.one_low <= cfg_wdata[4:0];
				CFG_RESET_GAP: timing_q.reset_gap <= cfg_wdata;
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	assign s_tready = !full;
	assign push = s_tvalid && !full;

	alebe_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pixel_word(s_tdata),
		.color_order(color_order_q),
		.frame_length(frame_length_q),
		.entry(push_entry)
	);

	alebe_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(full),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.head_pop(head_pop)
	);

	alebe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.head_pop(head_pop),
		.timing(timing_q),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for addressable_led_bit_encoder_unit.
// Drives pixel beats and register writes, predicts every bit symbol and compares it.
// Depends on alebe_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_top;
	import alebe_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned RANDOM_PHASES = 4;
	localparam int unsigned PIXELS_PER_PHASE = 20;
	localparam int unsigned FULL_RATE_PIXELS = 30;
	// spare register index and colour orders that the block must treat as rgb
	localparam logic [2:0] CFG_NONE = 3'd7;
	localparam logic [2:0] ORDER_SPARE6 = 3'd6;
	localparam logic [2:0] ORDER_SPARE7 = 3'd7;

	typedef struct packed {
		logic bit_value;
		logic [5:0] high_cycles;
		logic [15:0] low_cycles;
		logic is_reset;
		logic is_last;
	} symbol_t;

	// one row of the directed plan: a register write, or a pixel with its wire word
	typedef struct packed {
		logic is_cfg;
		logic [2:0] idx;
		logic [23:0] data;
		logic [23:0] exp_wire;
		logic exp_end;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata; // bit_value, high_cycles[5:0], low_cycles[15:0], pad
	logic m_tuser; // is_reset
	logic m_tlast;

	// predictor copy of the registers and the frame counter
	logic [2:0] p_order = RST_COLOR_ORDER;
	logic [10:0] p_frame_len = RST_FRAME_LENGTH;
	logic [4:0] p_zero_hi = RST_ZERO_HIGH;
	logic [5:0] p_zero_lo = RST_ZERO_LOW;
	logic [5:0] p_one_hi = RST_ONE_HIGH;
	logic [4:0] p_one_lo = RST_ONE_LOW;
	logic [15:0] p_gap = RST_RESET_GAP;
	logic [10:0] p_count = '0;

	symbol_t symbol_q[$];
	row_t plan[$];
	int unsigned mismatches = 0;
	int unsigned beat_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned ready_hold = 0;
	bit idle_on = 1'b1;

	addressable_led_bit_encoder_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// sink: while idle_on is set, alternate random ready stretches with stall bursts; else stay ready
	always @(posedge clk) begin
		if (!idle_on) begin
			m_tready <= 1'b1;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			m_tready <= 1'b0;
			ready_hold <= $urandom_range(0, 17);
		end else begin
			m_tready <= 1'b1;
			ready_hold <= $urandom_range(0, 39);
		end
	end

	// sample at the falling edge: the beat completes at the next rising edge
	always @(negedge clk) begin : symbol_check
		symbol_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[0], m_tdata[6:1], m_tdata[22:7], m_tuser, m_tlast};
			if (symbol_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("beat %0d: unexpected symbol bit=%0b hi=%0d lo=%0d rst=%0b last=%0b",
						beat_cnt, got.bit_value, got.high_cycles, got.low_cycles,
						got.is_reset, got.is_last);
			end else begin
				want = symbol_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"beat %0d: exp bit=%0b hi=%0d lo=%0d rst=%0b last=%0b",
							" got bit=%0b hi=%0d lo=%0d rst=%0b last=%0b"},
							beat_cnt, want.bit_value, want.high_cycles, want.low_cycles,
							want.is_reset, want.is_last, got.bit_value, got.high_cycles,
							got.low_cycles, got.is_reset, got.is_last);
				end
			end
			beat_cnt++;
		end
	end

	function automatic logic [23:0] wire_order(logic [23:0] px);
		logic [7:0] r, g, b;
		r = px[23:16];
		g = px[15:8];
		b = px[7:0];
		case (p_order)
			ORDER_RBG: return {r, b, g};
			ORDER_GRB: return {g, r, b};
			ORDER_GBR: return {g, b, r};
			ORDER_BRG: return {b, r, g};
			ORDER_BGR: return {b, g, r};
			default: return {r, g, b};
		endcase
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
			CFG_COLOR_ORDER: p_order = val[2:0];
			CFG_FRAME_LENGTH: p_frame_len = val[10:0];
			CFG_ZERO_HIGH: p_zero_hi = val[4:0];
			CFG_ZERO_LOW: p_zero_lo = val[5:0];
			CFG_ONE_HIGH: p_one_hi = val[5:0];
			CFG_ONE_LOW: p_one_lo = val[4:0];
			CFG_RESET_GAP: p_gap = val;
			default: ;
		endcase
	endfunction

	// advance the frame counter and return the wire word and the frame end
	function automatic void encode_pixel(input logic [23:0] px, output logic [23:0] wire_w,
		output logic fend);
		logic [10:0] eff_len, next_cnt;
		eff_len = p_frame_len;
		if (eff_len == '0)
			eff_len = 11'd1;
		if (eff_len > MAX_PIXELS)
			eff_len = MAX_PIXELS;
		next_cnt = p_count + 11'd1;
		fend = next_cnt >= eff_len;
		wire_w = wire_order(px);
		p_count = fend ? '0 : next_cnt;
	endfunction

	function automatic void push_symbols(logic [23:0] wire_w, logic fend);
		symbol_t s;
		for (int i = 23; i >= 0; i--) begin
			s.bit_value = wire_w[i];
			s.high_cycles = wire_w[i] ? p_one_hi : {1'b0, p_zero_hi};
			s.low_cycles = wire_w[i] ? {11'd0, p_one_lo} : {10'd0, p_zero_lo};
			s.is_reset = 1'b0;
			s.is_last = (i == 0) && !fend;
			symbol_q.push_back(s);
		end
		if (fend)
			symbol_q.push_back({1'b0, 6'd0, p_gap, 1'b1, 1'b1});
	endfunction

	function automatic row_t cfg_row(logic [2:0] idx, logic [15:0] val);
		return {1'b1, idx, {8'h00, val}, 24'h000000, 1'b0};
	endfunction

	function automatic row_t px_row(logic [23:0] px, logic [23:0] wire_w, logic fend);
		return {1'b0, 3'd0, px, wire_w, fend};
	endfunction

	// hold cfg_we high afterwards; the next pixel beat drops it
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		apply_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [23:0] px);
		int unsigned gap;
		logic taken;
		cfg_we <= 1'b0;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (symbol_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [23:0] random_pixel();
		case ($urandom_range(0, 7))
			0: return 24'h000000;
			1: return 24'hffffff;
			2: return 24'($urandom_range(0, 255)) << (8 * $urandom_range(0, 2));
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] random_frame_length();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'($urandom_range(2, 6));
			3: return 16'($urandom_range(7, 40));
			4: return 16'($urandom_range(1, 3)) | 16'($urandom() & 32'hf800);
			default: return 16'($urandom());
		endcase
	endfunction

	initial begin : stimulus
		logic [23:0] wire_w, px;
		logic fend;
		row_t r;

		plan = '{
			px_row(24'h000000, 24'h000000, 1'b1),
			px_row(24'hffffff, 24'hffffff, 1'b1),
			px_row(24'h123456, 24'h341256, 1'b1),
			cfg_row(CFG_COLOR_ORDER, {13'd0, ORDER_RGB}),
			px_row(24'ha5c3e1, 24'ha5c3e1, 1'b1),
			cfg_row(CFG_COLOR_ORDER, {13'd0, ORDER_RBG}),
			px_row(24'h112233, 24'h113322, 1'b1),
			cfg_row(CFG_COLOR_ORDER, {13'd0, ORDER_GBR}),
			px_row(24'h112233, 24'h223311, 1'b1),
			cfg_row(CFG_COLOR_ORDER, {13'd0, ORDER_BRG}),
			px_row(24'h112233, 24'h331122, 1'b1),
			cfg_row(CFG_COLOR_ORDER, {13'd0, ORDER_BGR}),
			px_row(24'h112233, 24'h332211, 1'b1),
			cfg_row(CFG_COLOR_ORDER, {13'd0, ORDER_SPARE6}),
			px_row(24'h112233, 24'h112233, 1'b1),
			// upper data bits must be dropped, leaving the other spare order
			cfg_row(CFG_COLOR_ORDER, {13'h1fff, ORDER_SPARE7}),
			px_row(24'h112233, 24'h112233, 1'b1),
			cfg_row(CFG_ZERO_HIGH, 16'd0),
			cfg_row(CFG_ZERO_LOW, 16'd63),
			cfg_row(CFG_ONE_HIGH, 16'd63),
			cfg_row(CFG_ONE_LOW, 16'd0),
			cfg_row(CFG_RESET_GAP, 16'd0),
			px_row(24'hf0f0f0, 24'hf0f0f0, 1'b1),
			cfg_row(CFG_ZERO_HIGH, 16'd31),
			cfg_row(CFG_ZERO_LOW, 16'd0),
			cfg_row(CFG_ONE_HIGH, 16'd0),
			cfg_row(CFG_ONE_LOW, 16'd31),
			cfg_row(CFG_RESET_GAP, 16'hffff),
			px_row(24'h5aa55a, 24'h5aa55a, 1'b1),
			// a write to the spare index must leave every register alone
			cfg_row(CFG_NONE, 16'h0000),
			px_row(24'h0000ff, 24'h0000ff, 1'b1),
			cfg_row(CFG_FRAME_LENGTH, 16'd0),
			px_row(24'h800001, 24'h800001, 1'b1),
			cfg_row(CFG_FRAME_LENGTH, 16'd3),
			px_row(24'hc0ffee, 24'hc0ffee, 1'b0),
			px_row(24'h0f1e2d, 24'h0f1e2d, 1'b0),
			px_row(24'h7ffffe, 24'h7ffffe, 1'b1),
			// shorten the frame after two pixels: the third one closes it
			cfg_row(CFG_FRAME_LENGTH, 16'd4),
			px_row(24'h010203, 24'h010203, 1'b0),
			px_row(24'h040506, 24'h040506, 1'b0),
			cfg_row(CFG_FRAME_LENGTH, 16'd2),
			px_row(24'h070809, 24'h070809, 1'b1)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			r = plan[i];
			if (r.is_cfg) begin
				wait_drained();
				write_reg(r.idx, r.data[15:0]);
			end else begin
				send_pixel(r.data);
				encode_pixel(r.data, wire_w, fend);
				// the typed wire word and frame end must agree with the predictor
				if (wire_w !== r.exp_wire || fend !== r.exp_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display("row %0d: exp wire=%06h end=%0b got wire=%06h end=%0b",
							i, r.exp_wire, r.exp_end, wire_w, fend);
				end
				push_symbols(wire_w, fend);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			write_reg(CFG_COLOR_ORDER, ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
				16'($urandom_range(0, 7)));
			write_reg(CFG_FRAME_LENGTH, random_frame_length());
			write_reg(CFG_ZERO_HIGH, 16'($urandom()));
			write_reg(CFG_ZERO_LOW, 16'($urandom()));
			write_reg(CFG_ONE_HIGH, 16'($urandom()));
			write_reg(CFG_ONE_LOW, 16'($urandom()));
			write_reg(CFG_RESET_GAP, 16'($urandom()));
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_NONE, 16'($urandom()));
			for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
				px = random_pixel();
				send_pixel(px);
				encode_pixel(px, wire_w, fend);
				push_symbols(wire_w, fend);
			end
		end

		// last stretch at full rate, with short frames so reset beats follow pixels
		wait_drained();
		idle_on = 1'b0;
		write_reg(CFG_FRAME_LENGTH, 16'd5);
		for (int k = 0; k < FULL_RATE_PIXELS; k++) begin
			px = 24'($urandom());
			send_pixel(px);
			encode_pixel(px, wire_w, fend);
			push_symbols(wire_w, fend);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && symbol_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
